### src/srgbde_pkg.sv
// ----------------------------------------------------------------------------
// srgbde_pkg: shared constants and tables for the sRGB pixel pair delta E block
// Holds the fixed-point formats, the gamma expansion table, the XYZ matrix
// with its white point divisors and the constants of the Lab curve.
// ----------------------------------------------------------------------------
package srgbde_pkg;

	localparam int LINEAR_BITS = 16;
	localparam int FRAC_BITS   = 8;

	localparam int CODE_W = 8;
	localparam int LIN_W  = LINEAR_BITS + 1;
	localparam int COEF_W = 24;
	localparam int PROD_W = LIN_W + COEF_W;
	localparam int SUM_W  = PROD_W;
	localparam int RECIP_W = SUM_W - 23;
	localparam int SPLIT  = SUM_W / 2;
	localparam int PP_W   = SUM_W + RECIP_W + 1;

	localparam int F_W      = 21;
	localparam int ROOT_STEPS = 21;
	localparam int CUBE_W   = 64;
	localparam int SQ2_W    = 43;

	localparam int LIN_B_W     = 24;
	localparam int LIN_HALF_W  = LIN_B_W / 2;
	localparam int LIN_RECIP_W = 25;
	localparam int LIN_PP_W    = LIN_HALF_W + LIN_RECIP_W;
	localparam int LIN_SUM_W   = LIN_B_W + LIN_RECIP_W + 1;
	localparam int LIN_SHIFT   = 31;
	localparam logic [LIN_RECIP_W-1:0] LIN_RECIP = LIN_RECIP_W'(((64'd1 << LIN_SHIFT) + 64'd124)
		/ 64'd125);
	localparam logic [F_W-1:0] LAB_OFFSET = F_W'((64'd16 << 20) / 64'd116);
	localparam logic [LIN_W-1:0] CUBE_THRESH = LIN_W'((64'd8856 << LINEAR_BITS) / 64'd1000000);

	localparam int D_W     = F_W + 2;
	localparam int MAG_W   = 31;
	localparam int SQR_W   = 2 * MAG_W;
	localparam int DSUM_W  = 64;
	localparam int ROOT_W  = 32;
	localparam int REM_W   = ROOT_W + 3;
	localparam int DIST_W  = 17;
	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	localparam int LANE_LAT  = 7 + 1 + ROOT_STEPS + 1;
	localparam int MERGE_LAT = 4 + ROOT_W + 1;
	localparam int TOTAL_LAT = LANE_LAT + MERGE_LAT;

	typedef logic [F_W-1:0] curve_t;
	typedef logic [LIN_W-1:0] gamma_table_t [256];

	function automatic gamma_table_t build_gamma_table();
		gamma_table_t tbl;
		longint unsigned code;
		longint unsigned c;
		longint unsigned c2;
		longint unsigned r;
		longint unsigned cand;
		longint unsigned p;
		longint unsigned lin30;
		for (int n = 0; n < 256; n++) begin
			code = longint'(n);
			if (code * 100000 <= 4045 * 255) begin
				tbl[n] = LIN_W'((((code * 10) << LINEAR_BITS) + 16473) / 32946);
			end else begin
				c = ((((1000 * code) + 14025) << 30) + 134512) / 269025;
				c2 = (c * c + (64'd1 << 29)) >> 30;
				r = 0;
				for (int b = 30; b >= 0; b--) begin
					cand = r | (64'd1 << b);
					if (cand <= (64'd1 << 30)) begin
						p = cand;
						for (int k = 0; k < 4; k++) begin
							p = (p * cand) >> 30;
						end
						if (p <= c2) begin
							r = cand;
						end
					end
				end
				lin30 = (c2 * r + (64'd1 << 29)) >> 30;
				tbl[n] = LIN_W'((lin30 + (64'd1 << (29 - LINEAR_BITS))) >> (30 - LINEAR_BITS));
			end
		end
		return tbl;
	endfunction

	localparam gamma_table_t GAMMA_TABLE = build_gamma_table();

	localparam logic [COEF_W-1:0] XYZ_COEF [3][3] = '{
		'{24'd4124564, 24'd3575761, 24'd1804375},
		'{24'd2126729, 24'd7151522, 24'd721750},
		'{24'd193339,  24'd1191920, 24'd9503041}
	};
	localparam logic [COEF_W-1:0] XYZ_DIV [3] = '{24'd9504700, 24'd10000000, 24'd10888300};
	localparam logic [COEF_W-1:0] XYZ_HALF [3] = '{24'd4752350, 24'd5000000, 24'd5444150};
	localparam logic [RECIP_W-1:0] XYZ_RECIP [3] = '{
		RECIP_W'((64'd1 << SUM_W) / 64'd9504700),
		RECIP_W'((64'd1 << SUM_W) / 64'd10000000),
		RECIP_W'((64'd1 << SUM_W) / 64'd10888300)
	};

endpackage

### src/srgbde_curve.sv
// ----------------------------------------------------------------------------
// srgbde_curve: Lab companding curve
// Takes a normalised tristimulus value and gives f(t) in Q20. The cube root
// is found one result bit per stage; the linear segment runs alongside.
// ----------------------------------------------------------------------------
module srgbde_curve (
	input  logic                          clk,
	input  logic                          ce,
	input  logic [srgbde_pkg::LIN_W-1:0]  t,
	output srgbde_pkg::curve_t            f
);

	logic [srgbde_pkg::CUBE_W-1:0]    tgt_s0;
	logic                             cube_s0;
	logic [srgbde_pkg::LIN_PP_W-1:0]  lplo_s0;
	logic [srgbde_pkg::LIN_PP_W-1:0]  lphi_s0;
	logic [srgbde_pkg::CUBE_W-1:0]    lin_num;
	logic [srgbde_pkg::LIN_B_W-1:0]   lin_b;
	logic [srgbde_pkg::LIN_SUM_W-1:0] lin_pp;
	srgbde_pkg::curve_t               lin_val;

	logic [srgbde_pkg::F_W-1:0]    root_s [srgbde_pkg::ROOT_STEPS];
	logic [srgbde_pkg::SQ2_W-1:0]  sq_s   [srgbde_pkg::ROOT_STEPS];
	logic [srgbde_pkg::CUBE_W-1:0] cb_s   [srgbde_pkg::ROOT_STEPS];
	logic [srgbde_pkg::CUBE_W-1:0] tgt_s  [srgbde_pkg::ROOT_STEPS];
	logic                          cube_s [srgbde_pkg::ROOT_STEPS];
	srgbde_pkg::curve_t            lin_s  [srgbde_pkg::ROOT_STEPS];

	assign lin_num = ((srgbde_pkg::CUBE_W'(t) * 64'd7787) << 20)
		+ (64'd500 << srgbde_pkg::LINEAR_BITS);
	assign lin_b = srgbde_pkg::LIN_B_W'(lin_num >> (srgbde_pkg::LINEAR_BITS + 3));

	always_ff @(posedge clk) begin
		if (ce) begin
			tgt_s0  <= srgbde_pkg::CUBE_W'(t) << (60 - srgbde_pkg::LINEAR_BITS);
			cube_s0 <= (t > srgbde_pkg::CUBE_THRESH);
			lplo_s0 <= srgbde_pkg::LIN_PP_W'(lin_b[srgbde_pkg::LIN_HALF_W-1:0])
				* srgbde_pkg::LIN_PP_W'(srgbde_pkg::LIN_RECIP);
			lphi_s0 <= srgbde_pkg::LIN_PP_W'(lin_b[srgbde_pkg::LIN_B_W-1:srgbde_pkg::LIN_HALF_W])
				* srgbde_pkg::LIN_PP_W'(srgbde_pkg::LIN_RECIP);
		end
	end

	assign lin_pp = (srgbde_pkg::LIN_SUM_W'(lphi_s0) << srgbde_pkg::LIN_HALF_W)
		+ srgbde_pkg::LIN_SUM_W'(lplo_s0);
	assign lin_val = srgbde_pkg::F_W'(lin_pp >> srgbde_pkg::LIN_SHIFT) + srgbde_pkg::LAB_OFFSET;

	for (genvar i = 0; i < srgbde_pkg::ROOT_STEPS; i++) begin : g_step
		localparam int B = srgbde_pkg::ROOT_STEPS - 1 - i;
		logic [srgbde_pkg::F_W-1:0]    root_in;
		logic [srgbde_pkg::SQ2_W-1:0]  sq_in;
		logic [srgbde_pkg::CUBE_W-1:0] cb_in;
		logic [srgbde_pkg::CUBE_W-1:0] tgt_in;
		logic                          cube_in;
		srgbde_pkg::curve_t            lin_in;
		logic [srgbde_pkg::CUBE_W-1:0] cand3;
		logic [srgbde_pkg::SQ2_W-1:0]  cand2;

		if (i == 0) begin : g_first
			assign root_in = '0;
			assign sq_in   = '0;
			assign cb_in   = '0;
			assign tgt_in  = tgt_s0;
			assign cube_in = cube_s0;
			assign lin_in  = lin_val;
		end else begin : g_next
			assign root_in = root_s[i-1];
			assign sq_in   = sq_s[i-1];
			assign cb_in   = cb_s[i-1];
			assign tgt_in  = tgt_s[i-1];
			assign cube_in = cube_s[i-1];
			assign lin_in  = lin_s[i-1];
		end

		assign cand3 = cb_in
			+ ((srgbde_pkg::CUBE_W'(sq_in) * 64'd3) << B)
			+ ((srgbde_pkg::CUBE_W'(root_in) * 64'd3) << (2 * B))
			+ (64'd1 << (3 * B));
		assign cand2 = sq_in + (srgbde_pkg::SQ2_W'(root_in) << (B + 1))
			+ (srgbde_pkg::SQ2_W'(1) << (2 * B));

		always_ff @(posedge clk) begin
			if (ce) begin
				tgt_s[i]  <= tgt_in;
				cube_s[i] <= cube_in;
				lin_s[i]  <= lin_in;
				if (cand3 <= tgt_in) begin
					root_s[i] <= root_in | (srgbde_pkg::F_W'(1) << B);
					sq_s[i]   <= cand2;
					cb_s[i]   <= cand3;
				end else begin
					root_s[i] <= root_in;
					sq_s[i]   <= sq_in;
					cb_s[i]   <= cb_in;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			f <= cube_s[srgbde_pkg::ROOT_STEPS-1] ? root_s[srgbde_pkg::ROOT_STEPS-1]
				: lin_s[srgbde_pkg::ROOT_STEPS-1];
		end
	end

endmodule

### src/srgbde_lane.sv
// ----------------------------------------------------------------------------
// srgbde_lane: one pixel from sRGB code to Lab curve values
// Gamma expansion by table, the XYZ matrix, division by the white point
// through a reciprocal with one correction step, then the Lab curve.
// ----------------------------------------------------------------------------
module srgbde_lane (
	input  logic                          clk,
	input  logic                          ce,
	input  logic [srgbde_pkg::CODE_W-1:0] red,
	input  logic [srgbde_pkg::CODE_W-1:0] green,
	input  logic [srgbde_pkg::CODE_W-1:0] blue,
	output srgbde_pkg::curve_t            f [3]
);

	logic [srgbde_pkg::LIN_W-1:0] lin_s1 [3];
	logic [srgbde_pkg::LIN_W-1:0] t_s7   [3];

	always_ff @(posedge clk) begin
		if (ce) begin
			lin_s1[0] <= srgbde_pkg::GAMMA_TABLE[red];
			lin_s1[1] <= srgbde_pkg::GAMMA_TABLE[green];
			lin_s1[2] <= srgbde_pkg::GAMMA_TABLE[blue];
		end
	end

	for (genvar row = 0; row < 3; row++) begin : g_row
		logic [srgbde_pkg::PROD_W-1:0]  prod_s2 [3];
		logic [srgbde_pkg::SUM_W-1:0]   sum_s3;
		logic [srgbde_pkg::PP_W-1:0]    plo_s4;
		logic [srgbde_pkg::PP_W-1:0]    phi_s4;
		logic [srgbde_pkg::SUM_W-1:0]   sum_s4;
		logic [srgbde_pkg::LIN_W-1:0]   est_s5;
		logic [srgbde_pkg::SUM_W-1:0]   sum_s5;
		logic [srgbde_pkg::PROD_W-1:0]  qd_s6;
		logic [srgbde_pkg::LIN_W-1:0]   est_s6;
		logic [srgbde_pkg::SUM_W-1:0]   sum_s6;
		logic [srgbde_pkg::PP_W-1:0]    pp_sum;
		logic [srgbde_pkg::SUM_W-1:0]   rem;

		assign pp_sum = (phi_s4 << srgbde_pkg::SPLIT) + plo_s4;
		assign rem = sum_s6 - srgbde_pkg::SUM_W'(qd_s6);

		always_ff @(posedge clk) begin
			if (ce) begin
				for (int c = 0; c < 3; c++) begin
					prod_s2[c] <= srgbde_pkg::PROD_W'(srgbde_pkg::XYZ_COEF[row][c])
						* srgbde_pkg::PROD_W'(lin_s1[c]);
				end
				sum_s3 <= prod_s2[0] + prod_s2[1] + prod_s2[2]
					+ srgbde_pkg::SUM_W'(srgbde_pkg::XYZ_HALF[row]);
				plo_s4 <= srgbde_pkg::PP_W'(sum_s3[srgbde_pkg::SPLIT-1:0])
					* srgbde_pkg::PP_W'(srgbde_pkg::XYZ_RECIP[row]);
				phi_s4 <= srgbde_pkg::PP_W'(sum_s3[srgbde_pkg::SUM_W-1:srgbde_pkg::SPLIT])
					* srgbde_pkg::PP_W'(srgbde_pkg::XYZ_RECIP[row]);
				sum_s4 <= sum_s3;
				est_s5 <= srgbde_pkg::LIN_W'(pp_sum >> srgbde_pkg::SUM_W);
				sum_s5 <= sum_s4;
				qd_s6  <= srgbde_pkg::PROD_W'(est_s5)
					* srgbde_pkg::PROD_W'(srgbde_pkg::XYZ_DIV[row]);
				est_s6 <= est_s5;
				sum_s6 <= sum_s5;
				t_s7[row] <= (rem >= srgbde_pkg::SUM_W'(srgbde_pkg::XYZ_DIV[row]))
					? est_s6 + srgbde_pkg::LIN_W'(1) : est_s6;
			end
		end

		srgbde_curve u_curve (
			.clk (clk),
			.ce  (ce),
			.t   (t_s7[row]),
			.f   (f[row])
		);
	end

endmodule

### src/srgbde_merge.sv
// ----------------------------------------------------------------------------
// srgbde_merge: combines the two lanes into the delta E distance
// Forms the Lab differences, squares and sums them, takes the integer square
// root one bit per stage and rounds to the output format with saturation.
// ----------------------------------------------------------------------------
module srgbde_merge (
	input  logic                          clk,
	input  logic                          ce,
	input  srgbde_pkg::curve_t            fa [3],
	input  srgbde_pkg::curve_t            fb [3],
	output logic [srgbde_pkg::DIST_W-1:0] distance
);

	logic signed [srgbde_pkg::D_W-1:0] dl_s1;
	logic signed [srgbde_pkg::D_W-1:0] da_s1;
	logic signed [srgbde_pkg::D_W-1:0] db_s1;
	logic signed [srgbde_pkg::D_W-1:0] xa;
	logic signed [srgbde_pkg::D_W-1:0] ya;
	logic signed [srgbde_pkg::D_W-1:0] za;
	logic signed [srgbde_pkg::D_W-1:0] xb;
	logic signed [srgbde_pkg::D_W-1:0] yb;
	logic signed [srgbde_pkg::D_W-1:0] zb;
	logic [srgbde_pkg::MAG_W-1:0]  ml_s2;
	logic [srgbde_pkg::MAG_W-1:0]  ma_s2;
	logic [srgbde_pkg::MAG_W-1:0]  mb_s2;
	logic [srgbde_pkg::SQR_W-1:0]  ql_s3;
	logic [srgbde_pkg::SQR_W-1:0]  qa_s3;
	logic [srgbde_pkg::SQR_W-1:0]  qb_s3;
	logic [srgbde_pkg::DSUM_W-1:0] sum_s4;

	logic [srgbde_pkg::DSUM_W-1:0] rad_s  [srgbde_pkg::ROOT_W];
	logic [srgbde_pkg::REM_W-1:0]  rem_s  [srgbde_pkg::ROOT_W];
	logic [srgbde_pkg::ROOT_W-1:0] root_s [srgbde_pkg::ROOT_W];
	logic [srgbde_pkg::ROOT_W:0]   rounded;

	function automatic logic [srgbde_pkg::MAG_W-1:0] mag_of(
		input logic signed [srgbde_pkg::D_W-1:0] d);
		logic [srgbde_pkg::D_W-1:0] u;
		u = (d < 0) ? -d : d;
		return srgbde_pkg::MAG_W'(u);
	endfunction

	assign xa = srgbde_pkg::D_W'(fa[0]);
	assign ya = srgbde_pkg::D_W'(fa[1]);
	assign za = srgbde_pkg::D_W'(fa[2]);
	assign xb = srgbde_pkg::D_W'(fb[0]);
	assign yb = srgbde_pkg::D_W'(fb[1]);
	assign zb = srgbde_pkg::D_W'(fb[2]);

	always_ff @(posedge clk) begin
		if (ce) begin
			dl_s1 <= yb - ya;
			da_s1 <= (xb - yb) - (xa - ya);
			db_s1 <= (yb - zb) - (ya - za);
			ml_s2 <= mag_of(dl_s1) * srgbde_pkg::MAG_W'(116);
			ma_s2 <= mag_of(da_s1) * srgbde_pkg::MAG_W'(500);
			mb_s2 <= mag_of(db_s1) * srgbde_pkg::MAG_W'(200);
			ql_s3 <= srgbde_pkg::SQR_W'(ml_s2) * srgbde_pkg::SQR_W'(ml_s2);
			qa_s3 <= srgbde_pkg::SQR_W'(ma_s2) * srgbde_pkg::SQR_W'(ma_s2);
			qb_s3 <= srgbde_pkg::SQR_W'(mb_s2) * srgbde_pkg::SQR_W'(mb_s2);
			sum_s4 <= srgbde_pkg::DSUM_W'(ql_s3) + srgbde_pkg::DSUM_W'(qa_s3)
				+ srgbde_pkg::DSUM_W'(qb_s3);
		end
	end

	for (genvar i = 0; i < srgbde_pkg::ROOT_W; i++) begin : g_sqrt
		logic [srgbde_pkg::DSUM_W-1:0] rad_in;
		logic [srgbde_pkg::REM_W-1:0]  rem_in;
		logic [srgbde_pkg::ROOT_W-1:0] root_in;
		logic [srgbde_pkg::REM_W-1:0]  rem_sh;
		logic [srgbde_pkg::REM_W-1:0]  trial;

		if (i == 0) begin : g_first
			assign rad_in  = sum_s4;
			assign rem_in  = '0;
			assign root_in = '0;
		end else begin : g_next
			assign rad_in  = rad_s[i-1];
			assign rem_in  = rem_s[i-1];
			assign root_in = root_s[i-1];
		end

		assign rem_sh = {rem_in[srgbde_pkg::REM_W-3:0],
			rad_in[srgbde_pkg::DSUM_W-1:srgbde_pkg::DSUM_W-2]};
		assign trial = {1'b0, root_in, 2'b01};

		always_ff @(posedge clk) begin
			if (ce) begin
				rad_s[i] <= rad_in << 2;
				if (rem_sh >= trial) begin
					rem_s[i]  <= rem_sh - trial;
					root_s[i] <= {root_in[srgbde_pkg::ROOT_W-2:0], 1'b1};
				end else begin
					rem_s[i]  <= rem_sh;
					root_s[i] <= {root_in[srgbde_pkg::ROOT_W-2:0], 1'b0};
				end
			end
		end
	end

	assign rounded = (srgbde_pkg::ROOT_W'(root_s[srgbde_pkg::ROOT_W-1]) + (srgbde_pkg::ROOT_W+1)'(0)
		+ ((srgbde_pkg::ROOT_W+1)'(1) << (19 - srgbde_pkg::FRAC_BITS)))
		>> (20 - srgbde_pkg::FRAC_BITS);

	always_ff @(posedge clk) begin
		if (ce) begin
			distance <= (rounded > (srgbde_pkg::ROOT_W+1)'(srgbde_pkg::DIST_MAX))
				? srgbde_pkg::DIST_MAX : srgbde_pkg::DIST_W'(rounded);
		end
	end

endmodule

### src/srgb_pixel_pair_delta_e_top.sv
// ----------------------------------------------------------------------------
// srgb_pixel_pair_delta_e_top: CIE76 colour difference of two sRGB pixels
// Two pixel lanes convert each pixel to Lab; a merging stage gives delta E.
// ----------------------------------------------------------------------------
// One pixel pair is taken per clock cycle while the output is not stalled, and
// the delay from a pair to its result is set mostly by the 21-stage cube-root
// pipeline in each lane and the 32-stage square-root pipeline of the merging
// stage. The pipeline moves as a whole: while a result is held on the output
// under stall, every stage holds and pair_stall is raised; otherwise a new
// transaction is accepted every cycle. color_distance is delta E with eight
// fraction bits, saturating at full scale.
module srgb_pixel_pair_delta_e_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pair_valid,
	output logic                          pair_stall,
	input  logic [srgbde_pkg::CODE_W-1:0] first_red,
	input  logic [srgbde_pkg::CODE_W-1:0] first_green,
	input  logic [srgbde_pkg::CODE_W-1:0] first_blue,
	input  logic [srgbde_pkg::CODE_W-1:0] second_red,
	input  logic [srgbde_pkg::CODE_W-1:0] second_green,
	input  logic [srgbde_pkg::CODE_W-1:0] second_blue,
	output logic                          dist_valid,
	input  logic                          dist_stall,
	output logic [srgbde_pkg::DIST_W-1:0] color_distance
);

	logic                              ce;
	logic [srgbde_pkg::TOTAL_LAT-1:0]  vld_q;
	srgbde_pkg::curve_t                lab_a [3];
	srgbde_pkg::curve_t                lab_b [3];

	assign dist_valid = vld_q[srgbde_pkg::TOTAL_LAT-1];
	assign ce = !(dist_valid && dist_stall);
	assign pair_stall = !ce;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ce) begin
			vld_q <= {vld_q[srgbde_pkg::TOTAL_LAT-2:0], pair_valid};
		end
	end

	srgbde_lane u_lane_first (
		.clk   (clk),
		.ce    (ce),
		.red   (first_red),
		.green (first_green),
		.blue  (first_blue),
		.f     (lab_a)
	);

	srgbde_lane u_lane_second (
		.clk   (clk),
		.ce    (ce),
		.red   (second_red),
		.green (second_green),
		.blue  (second_blue),
		.f     (lab_b)
	);

	srgbde_merge u_merge (
		.clk      (clk),
		.ce       (ce),
		.fa       (lab_a),
		.fb       (lab_b),
		.distance (color_distance)
	);

endmodule

### src/srgbde_checker.sv
// ----------------------------------------------------------------------------
// srgbde_checker: port-level checks for the delta E block
// Watches both channels and the coupling of the input stall to the output.
// ----------------------------------------------------------------------------
module srgbde_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          pair_valid,
	input logic                          pair_stall,
	input logic                          dist_valid,
	input logic                          dist_stall,
	input logic [srgbde_pkg::DIST_W-1:0] color_distance
);

	// An input transaction that is held back stays offered.
	a_input_held: assert property (@(posedge clk) disable iff (!arst_n)
		pair_valid && pair_stall |=> pair_valid)
		else $error("input withdrawn while stalled");

	// A result that is not taken stays offered.
	a_valid_held: assert property (@(posedge clk) disable iff (!arst_n)
		dist_valid && dist_stall |=> dist_valid)
		else $error("result withdrawn while stalled");

	// A result that is not taken keeps its value.
	a_payload_held: assert property (@(posedge clk) disable iff (!arst_n)
		dist_valid && dist_stall |=> $stable(color_distance))
		else $error("result changed while stalled");

	// The input is held back only by a waiting result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		pair_stall |-> dist_valid && dist_stall)
		else $error("input stalled without a waiting result");

	// A waiting result always holds back the input.
	a_stall_needed: assert property (@(posedge clk) disable iff (!arst_n)
		dist_valid && dist_stall |-> pair_stall)
		else $error("input taken while the pipeline is frozen");

endmodule

bind srgb_pixel_pair_delta_e_top srgbde_checker u_srgbde_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.pair_valid     (pair_valid),
	.pair_stall     (pair_stall),
	.dist_valid     (dist_valid),
	.dist_stall     (dist_stall),
	.color_distance (color_distance)
);
